// ===== hw/rtl/rbc_pkg.sv =====
// Package for the byte run-length compressor: run limits and code types shared by
// the encoder, serializer and top level, and the run-code function of the encoder.
// Depends on nothing.
package rbc_pkg;

    localparam int unsigned LenW    = 30;
    localparam int unsigned MaxOut  = 7;
    localparam int unsigned RunBytes = 6;

    localparam logic [LenW-1:0] RunMax     = 30'h3FFF_FFFF;
    localparam logic [LenW-1:0] LimitType0 = 30'd63;
    localparam logic [LenW-1:0] LimitType1 = 30'd16383;
    localparam logic [LenW-1:0] LimitType2 = 30'd4194303;

    // Count-word type codes (two low bits of the word)
    typedef enum logic [1:0] {
        CW_ONE   = 2'd0,
        CW_TWO   = 2'd1,
        CW_THREE = 2'd2,
        CW_FOUR  = 2'd3
    } t_cw_type;

    // Code bytes of one run, count 0 to 6
    typedef struct packed {
        logic [RunBytes-1:0][7:0] bytes;
        logic [2:0]               count;
    } t_run_code;

    // Code bytes of one input request, count 0 to 7
    typedef struct packed {
        logic [MaxOut-1:0][7:0] bytes;
        logic [2:0]             count;
        logic                   eob;
    } t_code;

    // Open-run state
    typedef struct packed {
        logic [7:0]      val;
        logic [LenW-1:0] len;
    } t_run_state;

    // Serializer status seen by the top level
    typedef struct packed {
        logic [2:0] left;
        logic       eob;
    } t_ser_stat;

    // Build the code of a run: nothing, bare byte, or byte twice and the count word
    function automatic t_run_code run_code(input logic [7:0] v, input logic [LenW-1:0] len);
        t_run_code rc;
        t_cw_type  ty;
        logic [2:0]  nb;
        logic [31:0] word;
        rc       = '0;
        ty       = CW_ONE;
        nb       = 3'd1;
        rc.bytes[0] = v;
        if (len == '0) begin
            rc.count = 3'd0;
        end else if (len == {{(LenW-1){1'b0}}, 1'b1}) begin
            rc.count = 3'd1;
        end else begin
            rc.bytes[1] = v;
            if (len <= LimitType0) begin
                ty = CW_ONE;
                nb = 3'd1;
            end else if (len <= LimitType1) begin
                ty = CW_TWO;
                nb = 3'd2;
            end else if (len <= LimitType2) begin
                ty = CW_THREE;
                nb = 3'd3;
            end else begin
                ty = CW_FOUR;
                nb = 3'd4;
            end
            word        = {len, ty};
            rc.bytes[2] = word[7:0];
            rc.bytes[3] = word[15:8];
            rc.bytes[4] = word[23:16];
            rc.bytes[5] = word[31:24];
            rc.count    = 3'd2 + nb;
        end
        return rc;
    endfunction

endpackage

// ===== hw/rtl/rbc_encode.sv =====
// Run tracker and code builder: next run state and the code bytes of one
// request. Pure combinational logic. Depends on rbc_pkg.
module rbc_encode
    import rbc_pkg::*;
(
    input  t_run_state i_state,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_block,
    output t_run_state o_next,
    output t_code      o_code
);

    logic            same;
    logic [LenW-1:0] inc;
    t_run_code       first;
    logic            tail;

    assign same = (i_state.len != '0) && (i_data_byte == i_state.val);
    assign inc  = i_state.len + {{(LenW-1){1'b0}}, 1'b1};

    // Decide which run closes and the new run state
    always_comb begin
        o_next = i_state;
        first  = '0;
        tail   = 1'b0;
        if (same) begin
            if (inc == RunMax) begin
                first      = run_code(i_state.val, RunMax);
                o_next.len = '0;
            end else if (i_end_of_block) begin
                first      = run_code(i_state.val, inc);
                o_next.len = '0;
            end else begin
                o_next.len = inc;
            end
        end else begin
            first      = run_code(i_state.val, i_state.len);
            o_next.val = i_data_byte;
            if (i_end_of_block) begin
                tail       = 1'b1;
                o_next.len = '0;
            end else begin
                o_next.len = {{(LenW-1){1'b0}}, 1'b1};
            end
        end
    end

    // Copy the closed run's bytes and append the single flushed byte after them
    always_comb begin
        for (int i = 0; i < RunBytes; i++) begin
            if (3'(i) < first.count) begin
                o_code.bytes[i] = first.bytes[i];
            end else begin
                o_code.bytes[i] = 8'h00;
            end
        end
        o_code.bytes[MaxOut-1] = 8'h00;
        for (int i = 0; i < MaxOut; i++) begin
            if (tail && 3'(i) == first.count) begin
                o_code.bytes[i] = i_data_byte;
            end
        end
        o_code.count = first.count + {2'b00, tail};
        o_code.eob   = i_end_of_block;
    end

endmodule

// ===== hw/rtl/rbc_serial.sv =====
// Output buffer: holds the code bytes of one request and shifts them out,
// one byte per accepted output request. Depends on rbc_pkg.
module rbc_serial
    import rbc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_code      i_code,
    output logic       o_can_load,
    output t_ser_stat  o_stat,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_item,
    output logic       o_end_of_stream,
    output logic       o_valid,
    input  logic       i_ready
);

    logic [MaxOut-1:0][7:0] r_buf;
    logic [2:0]             r_left;
    logic                   r_eob;
    logic                   take;

    assign take       = o_valid && i_ready;
    assign o_valid    = (r_left != 3'd0);
    assign o_can_load = (r_left == 3'd0) || ((r_left == 3'd1) && i_ready);

    assign o_out_byte      = r_buf[0];
    assign o_last_of_item  = (r_left == 3'd1);
    assign o_end_of_stream = (r_left == 3'd1) && r_eob;
    assign o_stat          = '{left: r_left, eob: r_eob};

    // Count down remaining bytes, reload on a new code
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 3'd0;
        end else if (i_load) begin
            r_left <= i_code.count;
        end else if (take) begin
            r_left <= r_left - 3'd1;
        end
    end

    // Load or advance the byte buffer
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_code.bytes;
            r_eob <= i_code.eob;
        end else if (take) begin
            r_buf <= {8'h00, r_buf[MaxOut-1:1]};
        end
    end

endmodule

// ===== hw/rtl/rle_byte_compressor_varlen_count_top.sv =====
// Top level of the byte run-length compressor with variable-length count.
// Depends on rbc_pkg, rbc_encode and rbc_serial.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  input   | i_valid / o_ready    | i_data_byte, i_end_of_block
//  output  | o_valid / i_ready    | o_out_byte, o_last_of_item, o_end_of_stream
//
// A request's 0 to 7 code bytes leave the output buffer one per cycle
// while i_ready is high, and the next request is taken in the cycle the
// last byte of the previous one is taken; the single output byte port
// sets how fast requests are taken.
// Synchronous active-low reset clears the open run and empties the buffer.
// Output stalls hold the buffer and drop o_ready while any byte is left;
// o_ready is also low whenever more than the last byte is left.
module rle_byte_compressor_varlen_count_top
    import rbc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_block,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_item,
    output logic       o_end_of_stream
);

    t_run_state r_run;
    t_run_state n_run;
    t_code      code;
    t_ser_stat  ser_stat;
    logic       accept;
    logic       can_load;

    assign o_ready = can_load;
    assign accept  = i_valid && can_load;

    rbc_encode u_encode (
        .i_state        (r_run),
        .i_data_byte    (i_data_byte),
        .i_end_of_block (i_end_of_block),
        .o_next         (n_run),
        .o_code         (code)
    );

    rbc_serial u_serial (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (accept && (code.count != 3'd0)),
        .i_code          (code),
        .o_can_load      (can_load),
        .o_stat          (ser_stat),
        .o_out_byte      (o_out_byte),
        .o_last_of_item  (o_last_of_item),
        .o_end_of_stream (o_end_of_stream),
        .o_valid         (o_valid),
        .i_ready         (i_ready)
    );

    // Advance the open run on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
        end else if (accept) begin
            r_run <= n_run;
        end
    end

`ifndef SYNTH
    // A full-length run is always closed in the cycle it is reached
    a_run_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run.len != RunMax)
        else $error("open run reached maximum length");

    // End of block leaves no open run
    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_end_of_block) |=> (r_run.len == '0))
        else $error("run still open after end of block");

    // No request is taken while more than the last byte is pending
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ser_stat.left > 3'd1) |-> !o_ready)
        else $error("request accepted over pending code bytes");

    // An end-of-block request always yields a final stream byte
    a_eob_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_end_of_block) |=> (o_valid && ser_stat.eob))
        else $error("end of block gave no code bytes");
`endif

endmodule
